[sv/gdsc_pkg.sv]
// Shared types, constants and calendar tables for the Gregorian date/serial converter.
package gdsc_pkg;

  typedef enum logic {
    CMD_TO_SERIAL = 1'b0,
    CMD_TO_DATE   = 1'b1
  } cmd_e;

  localparam int unsigned NumStages = 9;
  localparam int unsigned BaseYear  = 1601;
  localparam logic [22:0] SerialMax = 23'h3F_FFFF;

  // Day counts of the leap cycles
  localparam int unsigned Days400 = 146097;
  localparam int unsigned Days100 = 36524;
  localparam int unsigned Days4   = 1461;
  localparam int unsigned Days1   = 365;

  // Reciprocals for constant division: q = (x * R) >> S, exact over the operand range
  localparam int unsigned Shift400 = 40;
  localparam logic [22:0] Recip400 =
    23'(((64'd1 << Shift400) + 64'(Days400) - 64'd1) / 64'(Days400));
  localparam int unsigned Shift100 = 34;
  localparam logic [18:0] Recip100 =
    19'(((64'd1 << Shift100) + 64'(Days100) - 64'd1) / 64'(Days100));
  localparam int unsigned Shift4 = 27;
  localparam logic [16:0] Recip4 =
    17'(((64'd1 << Shift4) + 64'(Days4) - 64'd1) / 64'(Days4));
  localparam int unsigned Shift25 = 16;
  localparam logic [11:0] Recip25 = 12'(((64'd1 << Shift25) + 64'd24) / 64'd25);

  // Days before the first of the month
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] month);
    logic [8:0] base;
    case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (month > 4'd2) && (month <= 4'd12)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  typedef struct packed {
    logic        ok;
    logic [21:0] serial;
  } enc_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        date_ok;
    logic [23:0] p25;
    logic        ser_ok;
    logic [21:0] t;
    logic [44:0] p400;
  } st1_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [13:0] n;
    logic        date_ok;
    logic [22:0] extra;
    logic        ser_ok;
    logic [4:0]  q400;
    logic [17:0] r1;
  } st2_t;

  typedef struct packed {
    cmd_e        cmd;
    enc_t        enc;
    logic        ser_ok;
    logic [4:0]  q400;
    logic [17:0] r1;
    logic [36:0] p100;
  } st3_t;

  typedef struct packed {
    cmd_e        cmd;
    enc_t        enc;
    logic        ser_ok;
    logic [4:0]  q400;
    logic [1:0]  q100;
    logic [15:0] r2;
  } st4_t;

  typedef struct packed {
    cmd_e        cmd;
    enc_t        enc;
    logic        ser_ok;
    logic [4:0]  q400;
    logic [1:0]  q100;
    logic [15:0] r2;
    logic [32:0] p4;
  } st5_t;

  typedef struct packed {
    cmd_e        cmd;
    enc_t        enc;
    logic        ser_ok;
    logic [4:0]  q400;
    logic [1:0]  q100;
    logic [4:0]  q4;
    logic [10:0] r3;
  } st6_t;

  typedef struct packed {
    cmd_e        cmd;
    enc_t        enc;
    logic        ser_ok;
    logic        leap;
    logic [8:0]  doy;
    logic [13:0] year;
  } st7_t;

  typedef struct packed {
    cmd_e        cmd;
    enc_t        enc;
    logic        ser_ok;
    logic        leap;
    logic [8:0]  doy;
    logic [13:0] year;
    logic [3:0]  month;
  } st8_t;

  typedef struct packed {
    logic [21:0] serial;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        valid_res;
  } st9_t;

endpackage

[sv/gregorian_date_serial_converter_top.sv]
// Pipelined converter between Gregorian dates and serial day numbers (day 1 = 1 Jan 1601).
//
//   channel  direction  handshake                  word
//   input    in         in_valid_i / in_stall_o    cmd, day_in, month_in, year_in, serial_in
//   output   out        out_valid_o / out_stall_i  serial_out, day_out, month_out, year_out,
//                                                  valid_res
//
// Nine register stages; one word per cycle while the output is not stalled.
// Depth is set by the serial-to-date path: three constant divisions (400-, 100-, 4-year
// cycles), each a reciprocal multiply stage followed by a remainder stage, then one stage
// for the year within a 4-year block, one for the month and one for the day.
// Reset clears the stage valid bits only; data registers are left as they are.
// A stalled word in the last stage freezes the whole pipe and raises in_stall_o in the
// same cycle; empty slots still move forward while the output is free.
module gregorian_date_serial_converter_top
  import gdsc_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  cmd_i,
  input  logic [4:0]  day_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [13:0] year_in_i,
  input  logic [21:0] serial_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] serial_out_o,
  output logic [4:0]  day_out_o,
  output logic [3:0]  month_out_o,
  output logic [13:0] year_out_o,
  output logic        valid_res_o
);

  // Last valid serial: 31 Dec MAX_YEAR
  localparam int unsigned LastYears  = MAX_YEAR - BaseYear + 1;
  localparam logic [22:0] LastSerial = 23'(LastYears * 365 + LastYears / 4
                                           - LastYears / 100 + LastYears / 400);

  logic [NumStages-1:0] vld_q;
  logic                 adv;

  st1_t st1_d, st1_q;
  st2_t st2_d, st2_q;
  st3_t st3_d, st3_q;
  st4_t st4_d, st4_q;
  st5_t st5_d, st5_q;
  st6_t st6_d, st6_q;
  st7_t st7_d, st7_q;
  st8_t st8_d, st8_q;
  st9_t st9_d, st9_q;

  // Whole pipe moves unless a finished word is held at the output
  assign adv        = !(vld_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 1: range checks, first reciprocal products
  always_comb begin
    st1_d.cmd     = cmd_e'(cmd_i);
    st1_d.year    = year_in_i;
    st1_d.month   = month_in_i;
    st1_d.day     = day_in_i;
    st1_d.date_ok = (year_in_i > 14'(BaseYear)) && (year_in_i <= 14'(MAX_YEAR)) &&
                    (month_in_i >= 4'd1) && (month_in_i <= 4'd12);
    // year/100 = (year/4)/25
    st1_d.p25     = 24'(year_in_i[13:2]) * 24'(Recip25);
    st1_d.ser_ok  = (serial_in_i != 22'd0) && ({1'b0, serial_in_i} <= LastSerial);
    st1_d.t       = serial_in_i - 22'd1;
    st1_d.p400    = 45'(serial_in_i - 22'd1) * 45'(Recip400);
  end

  // Stage 2: leap test and day check for encode; 400-year remainder for decode
  always_comb begin
    logic [11:0] y4;
    logic [7:0]  q;
    logic        z4, z100, z400, leap;
    y4   = st1_q.year[13:2];
    q    = st1_q.p25[23:16];
    z4   = (st1_q.year[1:0] == 2'd0);
    z100 = z4 && (y4 == 12'({4'd0, q} * 12'd25));
    z400 = z100 && (q[1:0] == 2'd0);
    leap = z4 && (!z100 || z400);

    st2_d.cmd     = st1_q.cmd;
    st2_d.n       = st1_q.year - 14'(BaseYear);
    st2_d.date_ok = st1_q.date_ok && (st1_q.day != 5'd0) &&
                    (st1_q.day <= month_len(leap, st1_q.month));
    // (y-1)/4 - (y-1)/100 + (y-1)/400 - 388 equals the leap days of the n whole years
    st2_d.extra   = 23'(y4) - 23'(z4) - 23'(q) + 23'(z100) + 23'(q[7:2]) - 23'(z400)
                    - 23'd388 + 23'(cum_days(leap, st1_q.month)) + 23'(st1_q.day);
    st2_d.ser_ok  = st1_q.ser_ok;
    st2_d.q400    = 5'(st1_q.p400 >> Shift400);
    st2_d.r1      = 18'(st1_q.t - 22'(5'(st1_q.p400 >> Shift400)) * 22'(Days400));
  end

  // Stage 3: encoded serial; 100-year product
  always_comb begin
    logic [22:0] v;
    v = 23'(st2_q.n) * 23'(Days1) + st2_q.extra;
    st3_d.cmd        = st2_q.cmd;
    st3_d.enc.ok     = st2_q.date_ok && (v <= SerialMax);
    st3_d.enc.serial = st3_d.enc.ok ? v[21:0] : 22'd0;
    st3_d.ser_ok     = st2_q.ser_ok;
    st3_d.q400       = st2_q.q400;
    st3_d.r1         = st2_q.r1;
    st3_d.p100       = 37'(st2_q.r1) * 37'(Recip100);
  end

  // Stage 4: 100-year quotient, clamped on the last day of a 400-year cycle
  always_comb begin
    logic [2:0] raw;
    logic [1:0] q100;
    raw  = 3'(st3_q.p100 >> Shift100);
    q100 = (raw > 3'd3) ? 2'd3 : raw[1:0];
    st4_d.cmd    = st3_q.cmd;
    st4_d.enc    = st3_q.enc;
    st4_d.ser_ok = st3_q.ser_ok;
    st4_d.q400   = st3_q.q400;
    st4_d.q100   = q100;
    st4_d.r2     = 16'(st3_q.r1 - 18'(q100) * 18'(Days100));
  end

  // Stage 5: 4-year product
  always_comb begin
    st5_d.cmd    = st4_q.cmd;
    st5_d.enc    = st4_q.enc;
    st5_d.ser_ok = st4_q.ser_ok;
    st5_d.q400   = st4_q.q400;
    st5_d.q100   = st4_q.q100;
    st5_d.r2     = st4_q.r2;
    st5_d.p4     = 33'(st4_q.r2) * 33'(Recip4);
  end

  // Stage 6: 4-year quotient and remainder
  always_comb begin
    logic [4:0] q4;
    q4 = 5'(st5_q.p4 >> Shift4);
    st6_d.cmd    = st5_q.cmd;
    st6_d.enc    = st5_q.enc;
    st6_d.ser_ok = st5_q.ser_ok;
    st6_d.q400   = st5_q.q400;
    st6_d.q100   = st5_q.q100;
    st6_d.q4     = q4;
    st6_d.r3     = 11'(st5_q.r2 - 16'(q4) * 16'(Days4));
  end

  // Stage 7: year within the 4-year block, day of year, leap flag, year
  always_comb begin
    logic [1:0] q1;
    q1 = 2'(st6_q.r3 >= 11'd365) + 2'(st6_q.r3 >= 11'd730) + 2'(st6_q.r3 >= 11'd1095);
    st7_d.cmd    = st6_q.cmd;
    st7_d.enc    = st6_q.enc;
    st7_d.ser_ok = st6_q.ser_ok;
    st7_d.doy    = 9'(st6_q.r3 - 11'(q1) * 11'(Days1)) + 9'd1;
    // Fourth year of a block is leap, except a century year that is not the 400th
    st7_d.leap   = (q1 == 2'd3) && ((st6_q.q4 != 5'd24) || (st6_q.q100 == 2'd3));
    st7_d.year   = 14'(BaseYear) + 14'(st6_q.q400) * 14'd400 + 14'(st6_q.q100) * 14'd100
                   + 14'(st6_q.q4) * 14'd4 + 14'(q1);
  end

  // Stage 8: month from parallel compares against the month starts
  always_comb begin
    logic [3:0] cnt;
    cnt = 4'd1;
    for (int mm = 2; mm <= 12; mm++) begin
      cnt = cnt + 4'(st7_q.doy > cum_days(st7_q.leap, 4'(mm)));
    end
    st8_d.cmd    = st7_q.cmd;
    st8_d.enc    = st7_q.enc;
    st8_d.ser_ok = st7_q.ser_ok;
    st8_d.leap   = st7_q.leap;
    st8_d.doy    = st7_q.doy;
    st8_d.year   = st7_q.year;
    st8_d.month  = cnt;
  end

  // Stage 9: day of month, output word; unused fields are zero
  always_comb begin
    st9_d = '0;
    if (st8_q.cmd == CMD_TO_SERIAL) begin
      st9_d.serial    = st8_q.enc.serial;
      st9_d.valid_res = st8_q.enc.ok;
    end else if (st8_q.ser_ok) begin
      st9_d.day       = 5'(st8_q.doy - cum_days(st8_q.leap, st8_q.month));
      st9_d.month     = st8_q.month;
      st9_d.year      = st8_q.year;
      st9_d.valid_res = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st1_q <= st1_d;
      st2_q <= st2_d;
      st3_q <= st3_d;
      st4_q <= st4_d;
      st5_q <= st5_d;
      st6_q <= st6_d;
      st7_q <= st7_d;
      st8_q <= st8_d;
      st9_q <= st9_d;
    end
  end

  assign out_valid_o  = vld_q[NumStages-1];
  assign serial_out_o = st9_q.serial;
  assign day_out_o    = st9_q.day;
  assign month_out_o  = st9_q.month;
  assign year_out_o   = st9_q.year;
  assign valid_res_o  = st9_q.valid_res;

  // Rejected input gives an all-zero word
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (serial_out_o == 22'd0 && day_out_o == 5'd0 && month_out_o == 4'd0 &&
       year_out_o == 14'd0))
    else $error("invalid result carries nonzero fields");

  // A valid word is either an encode (serial only) or a decode (date only)
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      ((serial_out_o != 22'd0) != (year_out_o != 14'd0)))
    else $error("result mixes serial and date fields");

  // Decoded dates have a month of 1..12 and a day of at least 1, at most 29 in February
  a_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o && year_out_o != 14'd0) |->
      (month_out_o >= 4'd1 && month_out_o <= 4'd12 && day_out_o >= 5'd1 &&
       (month_out_o != 4'd2 || day_out_o <= 5'd29)))
    else $error("decoded date out of calendar range");

  // Reciprocal divisions leave remainders inside one 4-year block
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (st6_q.q4 <= 5'd24 && st6_q.r3 <= 11'd1460))
    else $error("4-year division out of range");

endmodule

[bench/gregorian_date_serial_converter_top_tb.sv]
// Testbench for the date / serial day number converter: queued driver, monitor, scoreboard.
`timescale 1ns / 1ps

module gregorian_date_serial_converter_top_tb;
  import gdsc_pkg::*;

  // Calendar constants of the bench's own predictor
  localparam int unsigned MaxYear    = 9999;
  localparam int unsigned EpochYear  = 1601;
  localparam int unsigned YearsSpan  = MaxYear - EpochYear + 1;
  // Serial of 31 Dec MaxYear: last serial that decodes
  localparam int unsigned LastSerial =
    YearsSpan * 365 + YearsSpan / 4 - YearsSpan / 100 + YearsSpan / 400;
  localparam int unsigned RandomWords = 1700;
  localparam int unsigned HoldCycles  = 80;    // long receiver hold-off
  localparam int unsigned HoldEvery   = 2000;  // receiver cycles between hold-offs
  localparam int unsigned TimeoutNs   = 400000;

  // One input word plus a flag that makes the sender wait for an empty pipe first
  typedef struct packed {
    cmd_e        cmd;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] serial;
    logic        drain;
  } date_word_t;

  // One result word
  typedef struct packed {
    logic [21:0] serial;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        ok;
  } conversion_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [0:0]  cmd_i       = '0;
  logic [4:0]  day_in_i    = '0;
  logic [3:0]  month_in_i  = '0;
  logic [13:0] year_in_i   = '0;
  logic [21:0] serial_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [21:0] serial_out_o;
  logic [4:0]  day_out_o;
  logic [3:0]  month_out_o;
  logic [13:0] year_out_o;
  logic        valid_res_o;

  date_word_t  queued_words[$];
  conversion_t awaited_results[$];
  int unsigned mismatches    = 0;
  logic        in_word_taken = 1'b0;  // input handshake seen at the last rising edge

  gregorian_date_serial_converter_top #(
    .MAX_YEAR(MaxYear)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .day_in_i    (day_in_i),
    .month_in_i  (month_in_i),
    .year_in_i   (year_in_i),
    .serial_in_i (serial_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .serial_out_o(serial_out_o),
    .day_out_o   (day_out_o),
    .month_out_o (month_out_o),
    .year_out_o  (year_out_o),
    .valid_res_o (valid_res_o)
  );

  // 2 ns clock, low half first so time zero carries no edge
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Days in the first n whole years counted from the epoch year
  function automatic int unsigned days_before_year(int unsigned n);
    return n * 365 + n / 4 - n / 100 + n / 400;
  endfunction

  // Days of the year before the first of month m (1..12)
  function automatic int unsigned month_start(bit leap, int unsigned m);
    int unsigned starts[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    return starts[m - 1] + ((leap && m > 2) ? 1 : 0);
  endfunction

  function automatic int unsigned month_days(bit leap, int unsigned m);
    return (m == 12) ? 31 : month_start(leap, m + 1) - month_start(leap, m);
  endfunction

  // Expected result word for one accepted input word; unused fields stay zero
  function automatic conversion_t convert_calendar(date_word_t w);
    conversion_t res;
    int unsigned y, m, d, s, v, n, doy, mo;
    bit          lp;
    res = '0;
    y = 32'(w.year);
    m = 32'(w.month);
    d = 32'(w.day);
    s = 32'(w.serial);
    if (w.cmd == CMD_TO_SERIAL) begin
      if (y > EpochYear && y <= MaxYear && m >= 1 && m <= 12) begin
        lp = leap_year(y);
        if (d >= 1 && d <= month_days(lp, m)) begin
          v = days_before_year(y - EpochYear) + month_start(lp, m) + d;
          // a serial past 22 bits counts as an invalid date
          if (v <= SerialMax) begin
            res.serial = v[21:0];
            res.ok     = 1'b1;
          end
        end
      end
    end else if (s >= 1 && s <= LastSerial) begin
      // year estimate from 365-day years, walked back to the right one
      n = s / 365;
      while (n > 0 && days_before_year(n) >= s) n--;
      doy = s - days_before_year(n);
      lp  = leap_year(EpochYear + n);
      mo  = 12;
      while (mo > 1 && doy <= month_start(lp, mo)) mo--;
      res.year  = 14'(EpochYear + n);
      res.month = 4'(mo);
      res.day   = 5'(doy - month_start(lp, mo));
      res.ok    = 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_word(cmd_e c, int unsigned d, int unsigned m, int unsigned y,
                            int unsigned s);
    date_word_t w;
    w.cmd    = c;
    w.day    = 5'(d);
    w.month  = 4'(m);
    w.year   = 14'(y);
    w.serial = 22'(s);
    w.drain  = 1'b0;
    queued_words.push_back(w);
  endtask

  // Mostly well-formed dates and in-range serials, with edges and full-range noise
  function automatic date_word_t random_word();
    date_word_t  w;
    int unsigned pick, len, base;
    w.cmd    = ($urandom_range(0, 1) == 0) ? CMD_TO_SERIAL : CMD_TO_DATE;
    w.day    = 5'($urandom);
    w.month  = 4'($urandom);
    w.year   = 14'($urandom);
    w.serial = 22'($urandom);
    w.drain  = 1'b0;
    pick     = $urandom_range(0, 9);
    if (w.cmd == CMD_TO_SERIAL) begin
      if (pick < 8) begin
        case ($urandom_range(0, 7))
          0:       w.year = 14'($urandom_range(EpochYear - 1, EpochYear + 2));
          1:       w.year = 14'($urandom_range(MaxYear - 1, MaxYear + 2));
          default: w.year = 14'($urandom_range(EpochYear + 1, MaxYear));
        endcase
        w.month = 4'($urandom_range(1, 12));
        len     = month_days(leap_year(32'(w.year)), 32'(w.month));
        // month-end edges: last day, one past it, or day zero
        if (pick < 6) w.day = 5'($urandom_range(1, len));
        else          w.day = 5'((pick == 6) ? len + $urandom_range(0, 1) : 0);
      end
    end else begin
      if (pick < 6) begin
        w.serial = 22'($urandom_range(1, LastSerial));
      end else if (pick < 8) begin
        // around a year boundary
        base     = days_before_year($urandom_range(0, YearsSpan - 1));
        w.serial = 22'(base + $urandom_range(0, 2));
      end else if (pick == 8) begin
        w.serial = 22'(LastSerial - 2 + $urandom_range(0, 4));
      end
    end
    return w;
  endfunction

  initial begin : stimulus
    date_word_t w;
    // directed: date to serial, field extremes and month-length edges
    queue_word(CMD_TO_SERIAL, 1, 1, 1602, 0);
    queue_word(CMD_TO_SERIAL, 31, 12, 9999, 0);
    queue_word(CMD_TO_SERIAL, 1, 1, 1601, 0);
    queue_word(CMD_TO_SERIAL, 15, 6, 0, 0);
    queue_word(CMD_TO_SERIAL, 1, 1, 10000, 0);
    queue_word(CMD_TO_SERIAL, 31, 15, 16383, 32'h3F_FFFF);
    queue_word(CMD_TO_SERIAL, 10, 0, 2000, 0);
    queue_word(CMD_TO_SERIAL, 10, 13, 2000, 0);
    queue_word(CMD_TO_SERIAL, 0, 5, 2000, 0);
    queue_word(CMD_TO_SERIAL, 31, 4, 2023, 0);
    queue_word(CMD_TO_SERIAL, 29, 2, 2000, 0);
    queue_word(CMD_TO_SERIAL, 29, 2, 1900, 0);
    queue_word(CMD_TO_SERIAL, 29, 2, 2004, 0);
    queue_word(CMD_TO_SERIAL, 30, 2, 2004, 0);
    queue_word(CMD_TO_SERIAL, 31, 12, 2000, 0);
    // directed: serial to date, range ends, year 1601 and leap-year corners
    queue_word(CMD_TO_DATE, 31, 15, 16383, 0);
    queue_word(CMD_TO_DATE, 0, 0, 0, 1);
    queue_word(CMD_TO_DATE, 0, 0, 0, 365);
    queue_word(CMD_TO_DATE, 0, 0, 0, 366);
    queue_word(CMD_TO_DATE, 0, 0, 0, LastSerial);
    queue_word(CMD_TO_DATE, 0, 0, 0, LastSerial + 1);
    queue_word(CMD_TO_DATE, 0, 0, 0, 32'h3F_FFFF);
    queue_word(CMD_TO_DATE, 0, 0, 0, days_before_year(399) + 60);
    queue_word(CMD_TO_DATE, 0, 0, 0, days_before_year(400));
    queue_word(CMD_TO_DATE, 0, 0, 0, days_before_year(299) + 1);
    // random part; twice the sender waits for an empty pipe first
    for (int i = 0; i < RandomWords; i++) begin
      w       = random_word();
      w.drain = (i == 0 || i == RandomWords / 2);
      queued_words.push_back(w);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every word offered and taken, then every result back
    while (queued_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (2 * NumStages) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps; a stalled word is held as it is
  // ---------------------------------------------------------------------------

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : driver
    date_word_t head_word;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_word_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (queued_words.size() == 0 ||
                   (queued_words[0].drain && awaited_results.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        head_word = queued_words.pop_front();
        cmd_i       <= head_word.cmd;
        day_in_i    <= head_word.day;
        month_in_i  <= head_word.month;
        year_in_i   <= head_word.year;
        serial_in_i <= head_word.serial;
        in_valid_i  <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a third of the bursts run straight into the next one
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall mode (never, a quarter, three quarters, alternating); a long
  // hold-off now and then fills the pipe while the sender keeps offering words
  // ---------------------------------------------------------------------------

  int unsigned rx_cycle   = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left  = 0;
  int unsigned next_hold  = 300;

  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left == 0 && rx_cycle >= next_hold && in_valid_i) begin
        hold_left = HoldCycles;
        next_hold = rx_cycle + HoldEvery;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= rx_cycle[1];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: predict at input handshake, compare at output one
  // ---------------------------------------------------------------------------

  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : monitor
    date_word_t  seen;
    conversion_t want, got;
    in_word_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen = '{cmd_e'(cmd_i), day_in_i, month_in_i, year_in_i, serial_in_i, 1'b0};
      awaited_results.push_back(convert_calendar(seen));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{serial_out_o, day_out_o, month_out_o, year_out_o, valid_res_o};
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, got);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got.serial !== want.serial)
          flag_field("serial_out", 32'(want.serial), 32'(got.serial));
        if (got.day !== want.day)
          flag_field("day_out", 32'(want.day), 32'(got.day));
        if (got.month !== want.month)
          flag_field("month_out", 32'(want.month), 32'(got.month));
        if (got.year !== want.year)
          flag_field("year_out", 32'(want.year), 32'(got.year));
        if (got.ok !== want.ok)
          flag_field("valid_res", 32'(want.ok), 32'(got.ok));
      end
    end
  end

endmodule
